@@ sv/crossing_state_detector_defines.svh @@
// Assertion macros for the crossing state detector.
`ifndef CROSSING_STATE_DETECTOR_DEFINES_SVH
`define CROSSING_STATE_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define CSD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("crossing_state_detector: assertion failed");
// Checked on every clock edge, reset included.
`define CSD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("crossing_state_detector: assertion failed");
`else
`define CSD_ASSERT(label, prop)
`define CSD_ASSERT_ALWAYS(label, prop)
`endif

`endif

@@ sv/csd_pkg.sv @@
// Types and constants shared by the crossing state detector modules.
package csd_pkg;

  localparam int ROW_BITS = 10;
  localparam int CNT_BITS = 4;
  localparam int ANGLE_BITS = 16;
  localparam int THR_BITS = 4;
  localparam int CFG_DATA_BITS = 10;
  localparam int CFG_INDEX_BITS = 2;

  // Track state codes carried in state_in and state_out.
  localparam logic [1:0] ST_NORMAL    = 2'd0;
  localparam logic [1:0] ST_CROSS_IN  = 2'd1;
  localparam logic [1:0] ST_CROSS_OUT = 2'd2;
  localparam logic [1:0] ST_OTHER     = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_ENTRY_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXIT_THRESHOLD  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_JUMP_ROWS       = 2'd2;

  localparam logic [THR_BITS-1:0] ENTRY_THRESHOLD_RESET = 4'd4;
  localparam logic [THR_BITS-1:0] EXIT_THRESHOLD_RESET  = 4'd6;
  localparam logic [ROW_BITS-1:0] JUMP_ROWS_RESET       = ROW_BITS'(20);

  typedef struct packed {
    logic [1:0]                   state_in;
    logic                         left_valid;
    logic signed [ANGLE_BITS-1:0] left_angle;
    logic [ROW_BITS-1:0]          left_row;
    logic                         right_valid;
    logic signed [ANGLE_BITS-1:0] right_angle;
    logic [ROW_BITS-1:0]          right_row;
  } item_t;

  typedef struct packed {
    logic [THR_BITS-1:0] entry_threshold;
    logic [THR_BITS-1:0] exit_threshold;
    logic [ROW_BITS-1:0] jump_rows;
  } cfg_t;

  // Tracking context carried from one item to the next.
  typedef struct packed {
    logic [CNT_BITS-1:0] count;
    logic [ROW_BITS-1:0] left_prev_row;
    logic                left_seen;
    logic [ROW_BITS-1:0] right_prev_row;
    logic                right_seen;
  } ctx_t;

endpackage

@@ sv/csd_update.sv @@
// Next track state and next tracking context for one item.
module csd_update (
  input  csd_pkg::item_t item,
  input  csd_pkg::cfg_t  cfg,
  input  csd_pkg::ctx_t  ctx,
  output logic [1:0]     state_out,
  output csd_pkg::ctx_t  ctx_next
);

  logic                          pair_found;
  logic                          both_absent;
  logic                          cnt_up;
  logic [csd_pkg::CNT_BITS-1:0]  cnt_step;
  logic [csd_pkg::ROW_BITS:0]    left_limit;
  logic [csd_pkg::ROW_BITS:0]    right_limit;
  logic                          left_jump;
  logic                          right_jump;

  // Left corner leaning one way, right corner leaning the other.
  assign pair_found = item.left_valid && item.left_angle[csd_pkg::ANGLE_BITS-1] &&
                      item.right_valid && (item.right_angle != '0) &&
                      !item.right_angle[csd_pkg::ANGLE_BITS-1];
  assign both_absent = !item.left_valid && !item.right_valid;
  assign cnt_up = (item.state_in == csd_pkg::ST_NORMAL) ? pair_found : both_absent;

  // Saturating up/down counter step.
  always_comb begin
    cnt_step = ctx.count;
    if (cnt_up) begin
      if (ctx.count != '1) cnt_step = ctx.count + 1'b1;
    end else if (ctx.count != '0) begin
      cnt_step = ctx.count - 1'b1;
    end
  end

  // A jump counts when the row moved up by at least jump_rows.
  assign left_limit  = {1'b0, item.left_row} + {1'b0, cfg.jump_rows};
  assign right_limit = {1'b0, item.right_row} + {1'b0, cfg.jump_rows};
  assign left_jump   = item.left_valid && ctx.left_seen &&
                       ({1'b0, ctx.left_prev_row} >= left_limit);
  assign right_jump  = item.right_valid && ctx.right_seen &&
                       ({1'b0, ctx.right_prev_row} >= right_limit);

  always_comb begin
    state_out = item.state_in;
    ctx_next  = ctx;
    case (item.state_in)
      csd_pkg::ST_NORMAL: begin
        ctx_next.count = cnt_step;
        if (cnt_step >= cfg.entry_threshold) begin
          state_out = csd_pkg::ST_CROSS_IN;
          ctx_next  = '0;
        end
      end
      csd_pkg::ST_CROSS_IN: begin
        if (left_jump || right_jump) state_out = csd_pkg::ST_CROSS_OUT;
        if (item.left_valid) begin
          ctx_next.left_prev_row = item.left_row;
          ctx_next.left_seen     = 1'b1;
        end
        if (item.right_valid) begin
          ctx_next.right_prev_row = item.right_row;
          ctx_next.right_seen     = 1'b1;
        end
      end
      csd_pkg::ST_CROSS_OUT: begin
        ctx_next.count = cnt_step;
        if (cnt_step >= cfg.exit_threshold) begin
          state_out      = csd_pkg::ST_NORMAL;
          ctx_next.count = '0;
        end
      end
      default: begin
        state_out = item.state_in;
        ctx_next  = ctx;
      end
    endcase
  end

endmodule

@@ sv/crossing_state_detector.sv @@
// An accepted item is captured by the input register, then by the result register once that
// is free or being read. Throughput: one item per cycle while m_axis_tready is high; the
// context update is a single pass of compares and a count step.
// While a result waits, the input register still takes one item, then the input stalls.
// Reset (rst, synchronous, active high) empties both stages, clears the counter and the
// remembered rows, and loads entry_threshold 4, exit_threshold 6 and jump_rows 20.
`include "crossing_state_detector_defines.svh"

module crossing_state_detector (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // state_in[1:0], left_valid[2], left_angle[18:3], left_row[28:19],
  // right_valid[29], right_angle[45:30], right_row[55:46]
  input  logic [55:0]                         s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // state_out[1:0], zero fill above
  output logic [7:0]                          m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [csd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [csd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  csd_pkg::cfg_t  cfg;
  csd_pkg::ctx_t  ctx;
  csd_pkg::ctx_t  ctx_next;
  csd_pkg::item_t in_item;
  logic           in_vld;
  logic           adv;
  logic [1:0]     state_next;
  logic [1:0]     out_state;
  logic           out_vld;

  assign adv           = in_vld && (!out_vld || m_axis_tready);
  assign s_axis_tready = !in_vld || adv;
  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {6'd0, out_state};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entry_threshold <= csd_pkg::ENTRY_THRESHOLD_RESET;
      cfg.exit_threshold  <= csd_pkg::EXIT_THRESHOLD_RESET;
      cfg.jump_rows       <= csd_pkg::JUMP_ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        csd_pkg::REG_ENTRY_THRESHOLD: cfg.entry_threshold <= cfg_data[csd_pkg::THR_BITS-1:0];
        csd_pkg::REG_EXIT_THRESHOLD:  cfg.exit_threshold  <= cfg_data[csd_pkg::THR_BITS-1:0];
        csd_pkg::REG_JUMP_ROWS:       cfg.jump_rows       <= cfg_data[csd_pkg::ROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld <= 1'b1;
    end else if (adv) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.state_in    <= s_axis_tdata[1:0];
      in_item.left_valid  <= s_axis_tdata[2];
      in_item.left_angle  <= s_axis_tdata[18:3];
      in_item.left_row    <= s_axis_tdata[28:19];
      in_item.right_valid <= s_axis_tdata[29];
      in_item.right_angle <= s_axis_tdata[45:30];
      in_item.right_row   <= s_axis_tdata[55:46];
    end
  end

  csd_update u_update (
    .item      (in_item),
    .cfg       (cfg),
    .ctx       (ctx),
    .state_out (state_next),
    .ctx_next  (ctx_next)
  );

  // The context moves only when an item leaves the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx <= '0;
    end else if (adv) begin
      ctx <= ctx_next;
    end
  end

  // Result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_state <= state_next;
  end

  `CSD_ASSERT_ALWAYS(a_empty_after_reset, rst |=> !m_axis_tvalid)
  `CSD_ASSERT(a_advance_fills_result, adv |=> m_axis_tvalid)
  `CSD_ASSERT(a_left_forgotten_row_zero, !ctx.left_seen |-> ctx.left_prev_row == '0)
  `CSD_ASSERT(a_right_forgotten_row_zero, !ctx.right_seen |-> ctx.right_prev_row == '0)
  `CSD_ASSERT(a_other_passes, (adv && in_item.state_in == csd_pkg::ST_OTHER) |=>
    (out_state == csd_pkg::ST_OTHER) && $stable(ctx))

endmodule
